@@ src/nr_frame_slot_timing_locator_defines.svh @@
// assertion macros for the nr frame slot timing locator checker
// depends on clk and rst_n being visible where a macro is used
`ifndef NR_FRAME_SLOT_TIMING_LOCATOR_DEFINES_SVH
`define NR_FRAME_SLOT_TIMING_LOCATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define NRFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrfs check failed");

// next-cycle implication, disabled while in reset
`define NRFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nrfs check failed");

`endif

@@ src/nrfs_pkg.sv @@
// shared types, constants and helpers for the nr frame slot timing locator
// no dependencies
package nrfs_pkg;

    // field widths
    localparam int unsigned FFT_W      = 13;
    localparam int unsigned MU_W       = 3;
    localparam int unsigned SFN_W      = 10;
    localparam int unsigned SLOT_W     = 8;
    localparam int unsigned SYM_W      = 4;
    localparam int unsigned SAMPLE_W   = 63;
    localparam int unsigned OFFSET_W   = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 13;

    localparam int unsigned MAX_NUMEROLOGY       = 4;
    localparam int unsigned FRAME_NUMBER_MODULUS = 1 << SFN_W;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FFT_SIZE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NUMEROLOGY  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SFN_AT_REF  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SLOT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SYMBOL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_READY  = 3'd5;

    localparam logic [FFT_W-1:0] FFT_SIZE_RESET = 13'd2048;

    // cyclic prefix arithmetic: (scale * n + round) >> shift
    localparam int unsigned CP_SHORT_SCALE = 144;
    localparam int unsigned CP_LONG_STEP   = 16;
    localparam int unsigned CP_ROUND       = 1024;
    localparam int unsigned CP_SHIFT       = 11;
    localparam int unsigned CP_PROD_W      = 25;
    localparam int unsigned CP_SCALE_W     = 12;

    localparam int unsigned SYMBOLS_PER_SLOT    = 14;
    localparam int unsigned SYMBOLS_HALF_SLOT   = 7;
    localparam int unsigned LONG_SYMS_PER_FRAME = 20;
    localparam int unsigned SLOTS_PER_FRAME_MU0 = 10;

    // datapath widths
    localparam int unsigned CP_W     = 14;
    localparam int unsigned SYMU_W   = 14;
    localparam int unsigned DLT_W    = 14;
    localparam int unsigned SLOT14_W = 18;
    localparam int unsigned SOFF_W   = 19;
    localparam int unsigned FLEN_W   = 27;
    localparam int unsigned REL_W    = 34;
    localparam int unsigned DIFF_W   = 35;
    localparam int unsigned WIDE_W   = 64;
    localparam int unsigned CNT_W    = 6;

    // datapath commands
    localparam int unsigned CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_NOP    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CP     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SLOT   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_S14    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_OFF    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_DIFF   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SUM    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 4'd8;
    localparam logic [CMD_W-1:0] CMD_FLEN   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_DIV    = 4'd10;
    localparam logic [CMD_W-1:0] CMD_POST   = 4'd11;
    localparam logic [CMD_W-1:0] CMD_WALK   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_FINAL  = 4'd13;
    localparam logic [CMD_W-1:0] CMD_REJECT = 4'd14;

    typedef struct packed {
        logic                       op;
        logic [SAMPLE_W-1:0]        block_first_sample;
        logic [OFFSET_W-1:0]        coarse_offset;
        logic signed [OFFSET_W-1:0] tracking_shift;
        logic [SAMPLE_W-1:0]        query_sample;
    } nrfs_item_t;

    typedef struct packed {
        logic                status;
        logic [SFN_W-1:0]    frame_number;
        logic [SLOT_W-1:0]   slot_number;
        logic [SAMPLE_W-1:0] slot_first_sample;
    } nrfs_result_t;

    typedef struct packed {
        logic [CMD_W-1:0] code;
    } nrfs_cmd_t;

    typedef struct packed {
        logic op_locate;
        logic pre_bad;
        logic slot_bad;
        logic ref_missing;
        logic div_last;
        logic walk_hit;
    } nrfs_stat_t;

    // long symbols in one slot
    function automatic logic [1:0] slot_long_syms(input logic [MU_W-1:0] mu,
                                                  input logic [SLOT_W-1:0] k);
        logic [SLOT_W-1:0] mask;
        logic [1:0]        n;
        mask = SLOT_W'((9'd1 << (mu - 3'd1)) - 9'd1);
        if (mu == '0)
            n = 2'd2;
        else if ((k & mask) == '0)
            n = 2'd1;
        else
            n = 2'd0;
        return n;
    endfunction

    // long symbols in the slots before a given slot
    function automatic logic [SLOT_W:0] long_before(input logic [MU_W-1:0] mu,
                                                    input logic [SLOT_W-1:0] count);
        logic [SLOT_W:0] bias;
        logic [SLOT_W:0] n;
        bias = (9'd1 << (mu - 3'd1)) - 9'd1;
        if (mu == '0)
            n = {count, 1'b0};
        else
            n = ({1'b0, count} + bias) >> (mu - 3'd1);
        return n;
    endfunction

endpackage

@@ src/nrfs_datapath.sv @@
// datapath of the timing locator: registers, cp arithmetic, divider, slot walk
// depends on nrfs_pkg
module nrfs_datapath
    import nrfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  nrfs_item_t            item,
    input  nrfs_cmd_t             cmd,
    output nrfs_stat_t            stat,
    output nrfs_result_t          result
);

    // configuration and reference state
    logic [FFT_W-1:0]    fft_size_reg;
    logic [MU_W-1:0]     numerology_reg;
    logic [SFN_W-1:0]    sfn_ref_reg;
    logic [SLOT_W-1:0]   sync_slot_reg;
    logic [SYM_W-1:0]    sync_symbol_reg;
    logic                cell_ready_reg;
    logic [SAMPLE_W-1:0] frame_start_reg;
    logic                ref_valid_reg;

    // working registers
    nrfs_item_t          item_reg;
    nrfs_result_t        res_reg;
    logic [CP_W-1:0]     short_reg;
    logic [CP_W-1:0]     long_reg;
    logic [SYMU_W-1:0]   symu_reg;
    logic [DLT_W-1:0]    dlt_reg;
    logic [SLOT14_W-1:0] slot14_reg;
    logic [SOFF_W-1:0]   soff_reg;
    logic [REL_W-1:0]    rel_reg;
    logic [DIFF_W-1:0]   diff_reg;
    logic [FLEN_W-1:0]   before_reg;
    logic [WIDE_W-1:0]   ss_reg;
    logic [FLEN_W-1:0]   flen_reg;
    logic                qneg_reg;
    logic [SAMPLE_W-1:0] quo_reg;
    logic [FLEN_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SFN_W-1:0]    frame_reg;
    logic [FLEN_W-1:0]   inf_reg;
    logic [FLEN_W-1:0]   wstart_reg;
    logic [SLOT_W-1:0]   k_reg;

    logic [SLOT_W-1:0]     spf;
    logic [SYM_W-1:0]      sym14;
    logic [CP_PROD_W-1:0]  prod_short;
    logic [CP_PROD_W-1:0]  prod_long;
    logic [CP_SCALE_W-1:0] long_scale;
    logic [1:0]            nlong_off;
    logic [FLEN_W+1:0]     trial;
    logic [FLEN_W:0]       shifted;
    logic                  qbit;
    logic                  rem_zero;
    logic [SFN_W-1:0]      adv;
    logic [FLEN_W-1:0]     slen;
    logic [FLEN_W-1:0]     wend;
    logic [FLEN_W-1:0]     back;
    logic                  commit_bad;
    logic [SAMPLE_W-1:0]   q;

    // frame geometry
    assign spf   = SLOT_W'(11'(SLOTS_PER_FRAME_MU0) << numerology_reg);
    assign sym14 = (sync_symbol_reg >= SYM_W'(SYMBOLS_PER_SLOT))
                   ? sync_symbol_reg - SYM_W'(SYMBOLS_PER_SLOT) : sync_symbol_reg;
    assign q     = item_reg.query_sample;

    // cyclic prefix products
    assign long_scale = CP_SCALE_W'(CP_SHORT_SCALE)
                        + (CP_SCALE_W'(CP_LONG_STEP) << numerology_reg);
    assign prod_short = CP_PROD_W'(fft_size_reg) * CP_PROD_W'(CP_SHORT_SCALE)
                        + CP_PROD_W'(CP_ROUND);
    assign prod_long  = CP_PROD_W'(fft_size_reg) * CP_PROD_W'(long_scale)
                        + CP_PROD_W'(CP_ROUND);

    // long symbols ahead of the sync block inside its slot
    assign nlong_off = 2'((sym14 != '0 && slot_long_syms(numerology_reg, sync_slot_reg) != '0)
                          ? 1 : 0)
                     + 2'((numerology_reg == '0 && sym14 > SYM_W'(SYMBOLS_HALF_SLOT)) ? 1 : 0);

    // one restoring division step
    assign shifted = {rem_reg, quo_reg[SAMPLE_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, flen_reg};
    assign qbit    = !trial[FLEN_W+1];

    // floor adjust for queries before the reference
    assign rem_zero = (rem_reg == '0);
    assign adv = !qneg_reg ? quo_reg[SFN_W-1:0]
               : (rem_zero ? (~quo_reg[SFN_W-1:0] + SFN_W'(1)) : ~quo_reg[SFN_W-1:0]);

    // slot walk
    assign slen = FLEN_W'(slot14_reg)
                + FLEN_W'(slot_long_syms(numerology_reg, k_reg)) * FLEN_W'(dlt_reg);
    assign wend = wstart_reg + slen;
    assign back = inf_reg - wstart_reg;

    assign commit_bad = diff_reg[DIFF_W-1] || ss_reg[WIDE_W-1]
                        || (ss_reg < WIDE_W'(before_reg));

    // status to the controller
    always_comb
    begin
        stat.op_locate   = item_reg.op;
        stat.pre_bad     = !cell_ready_reg || (numerology_reg > MU_W'(MAX_NUMEROLOGY));
        stat.slot_bad    = (sync_slot_reg >= spf);
        stat.ref_missing = !ref_valid_reg || (fft_size_reg == '0);
        stat.div_last    = (cnt_reg == CNT_W'(1));
        stat.walk_hit    = (inf_reg < wend) || (k_reg == spf - SLOT_W'(1));
    end

    assign result = res_reg;

    // configuration and reference state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fft_size_reg    <= FFT_SIZE_RESET;
            numerology_reg  <= '0;
            sfn_ref_reg     <= '0;
            sync_slot_reg   <= '0;
            sync_symbol_reg <= '0;
            cell_ready_reg  <= 1'b0;
            frame_start_reg <= '0;
            ref_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_FFT_SIZE:    fft_size_reg    <= cfg_wdata[FFT_W-1:0];
                    REG_NUMEROLOGY:  numerology_reg  <= cfg_wdata[MU_W-1:0];
                    REG_SFN_AT_REF:  sfn_ref_reg     <= cfg_wdata[SFN_W-1:0];
                    REG_SYNC_SLOT:   sync_slot_reg   <= cfg_wdata[SLOT_W-1:0];
                    REG_SYNC_SYMBOL: sync_symbol_reg <= cfg_wdata[SYM_W-1:0];
                    REG_CELL_READY:  cell_ready_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (cmd.code == CMD_COMMIT && !commit_bad)
            begin
                frame_start_reg <= ss_reg[SAMPLE_W-1:0] - SAMPLE_W'(before_reg);
                ref_valid_reg   <= 1'b1;
            end
        end
    end

    // working registers, one command per cycle
    always_ff @(posedge clk)
    begin
        case (cmd.code)
            CMD_LOAD:
            begin
                item_reg <= item;
            end
            CMD_CP:
            begin
                short_reg <= CP_W'(prod_short >> CP_SHIFT);
                long_reg  <= CP_W'(prod_long >> CP_SHIFT);
            end
            CMD_SLOT:
            begin
                symu_reg <= SYMU_W'(fft_size_reg) + short_reg;
                dlt_reg  <= long_reg - short_reg;
            end
            CMD_S14:
            begin
                slot14_reg <= SLOT14_W'(symu_reg) * SLOT14_W'(SYMBOLS_PER_SLOT);
            end
            CMD_OFF:
            begin
                soff_reg <= SOFF_W'(sym14) * SOFF_W'(symu_reg)
                          + SOFF_W'(nlong_off) * SOFF_W'(dlt_reg);
                rel_reg  <= {2'b00, item_reg.coarse_offset}
                          + {{2{item_reg.tracking_shift[OFFSET_W-1]}}, item_reg.tracking_shift};
            end
            CMD_DIFF:
            begin
                diff_reg   <= {rel_reg[REL_W-1], rel_reg} - DIFF_W'(soff_reg);
                before_reg <= FLEN_W'(sync_slot_reg) * FLEN_W'(slot14_reg)
                            + FLEN_W'(long_before(numerology_reg, sync_slot_reg))
                              * FLEN_W'(dlt_reg);
            end
            CMD_SUM:
            begin
                ss_reg <= {1'b0, item_reg.block_first_sample} + WIDE_W'(diff_reg[REL_W-1:0]);
            end
            CMD_COMMIT:
            begin
                res_reg <= '{status: commit_bad, frame_number: '0, slot_number: '0,
                             slot_first_sample: '0};
            end
            CMD_FLEN:
            begin
                flen_reg <= FLEN_W'(spf) * FLEN_W'(slot14_reg)
                          + FLEN_W'(LONG_SYMS_PER_FRAME) * FLEN_W'(dlt_reg);
                qneg_reg <= (q < frame_start_reg);
                quo_reg  <= (q < frame_start_reg) ? frame_start_reg - q : q - frame_start_reg;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(SAMPLE_W);
            end
            CMD_DIV:
            begin
                rem_reg <= qbit ? trial[FLEN_W-1:0] : shifted[FLEN_W-1:0];
                quo_reg <= {quo_reg[SAMPLE_W-2:0], qbit};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            CMD_POST:
            begin
                frame_reg  <= sfn_ref_reg + adv;
                inf_reg    <= !qneg_reg ? rem_reg : (rem_zero ? '0 : flen_reg - rem_reg);
                wstart_reg <= '0;
                k_reg      <= '0;
            end
            CMD_WALK:
            begin
                wstart_reg <= wend;
                k_reg      <= k_reg + SLOT_W'(1);
            end
            CMD_FINAL:
            begin
                res_reg <= '{status: 1'b0, frame_number: frame_reg, slot_number: k_reg,
                             slot_first_sample: (SAMPLE_W'(back) > q) ? '0
                                                : q - SAMPLE_W'(back)};
            end
            CMD_REJECT:
            begin
                res_reg <= '{status: 1'b1, frame_number: '0, slot_number: '0,
                             slot_first_sample: '0};
            end
            default: ;
        endcase
    end

endmodule

@@ src/nrfs_ctrl.sv @@
// controller state machine sequencing the timing locator datapath
// depends on nrfs_pkg
module nrfs_ctrl
    import nrfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  nrfs_stat_t stat,
    output nrfs_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CP     = 4'd1;
    localparam logic [3:0] ST_SLOT   = 4'd2;
    localparam logic [3:0] ST_S14    = 4'd3;
    localparam logic [3:0] ST_CHK    = 4'd4;
    localparam logic [3:0] ST_OFF    = 4'd5;
    localparam logic [3:0] ST_DIFF   = 4'd6;
    localparam logic [3:0] ST_SUM    = 4'd7;
    localparam logic [3:0] ST_COMMIT = 4'd8;
    localparam logic [3:0] ST_FLEN   = 4'd9;
    localparam logic [3:0] ST_DIV    = 4'd10;
    localparam logic [3:0] ST_POST   = 4'd11;
    localparam logic [3:0] ST_WALK   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       done_reg;
    logic       done_next;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.code   = CMD_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.code   = CMD_LOAD;
                    state_next = ST_CP;
                end
            end
            ST_CP:
            begin
                cmd.code   = CMD_CP;
                state_next = ST_SLOT;
            end
            ST_SLOT:
            begin
                cmd.code   = CMD_SLOT;
                state_next = ST_S14;
            end
            ST_S14:
            begin
                cmd.code   = CMD_S14;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (stat.pre_bad
                    || (!stat.op_locate && stat.slot_bad)
                    || (stat.op_locate && stat.ref_missing))
                begin
                    cmd.code   = CMD_REJECT;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else if (stat.op_locate)
                    state_next = ST_FLEN;
                else
                    state_next = ST_OFF;
            end
            ST_OFF:
            begin
                cmd.code   = CMD_OFF;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.code   = CMD_DIFF;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.code   = CMD_SUM;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.code   = CMD_COMMIT;
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            ST_FLEN:
            begin
                cmd.code   = CMD_FLEN;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.code = CMD_DIV;
                if (stat.div_last)
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                cmd.code   = CMD_POST;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (stat.walk_hit)
                begin
                    cmd.code   = CMD_FINAL;
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                    cmd.code = CMD_WALK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ src/nr_frame_slot_timing_locator.sv @@
// top level of the nr frame and slot timing locator
// depends on nrfs_pkg, nrfs_ctrl and nrfs_datapath
//
// channel   | signals                          | beat taken when
// ----------+----------------------------------+-----------------------
// command   | start, busy, item                | start && !busy
// result    | done, result                     | done (single cycle)
// config    | cfg_wr_en, cfg_addr, cfg_wdata   | cfg_wr_en
//
// a set-reference beat steps through load, cp, slot, s14, check, off, diff, sum and commit,
// a beat rejected at the check ends there; a locate beat runs 63 divider steps plus one
// walk step per slot walked before the hit slot (a frame holds up to 160 slots)
// rst_n is asynchronous and clears configuration and the stored reference
// results cannot be stalled; a new beat is taken in the cycle done is high
module nr_frame_slot_timing_locator
    import nrfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  nrfs_item_t            item,
    output logic                  done,
    output nrfs_result_t          result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    nrfs_cmd_t  cmd;
    nrfs_stat_t stat;

    // sequencer
    nrfs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // arithmetic and state
    nrfs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule

@@ src/nrfs_checker.sv @@
// port-level checker for the timing locator, bound to the top level
// depends on nrfs_pkg and nr_frame_slot_timing_locator_defines.svh
`include "nr_frame_slot_timing_locator_defines.svh"

module nrfs_checker
    import nrfs_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         done,
    input nrfs_result_t result
);

    // result beat comes as the block goes idle
    `NRFS_ASSERT_IMP(a_done_idle, done, !busy)

    // a taken command beat makes the block busy
    `NRFS_ASSERT_NXT(a_start_busy, start && !busy, busy)

    // rejected beats carry zero fields
    `NRFS_ASSERT_IMP(a_reject_zero, done && result.status, result.frame_number == '0 && result.slot_number == '0 && result.slot_first_sample == '0)

    // a located slot lies inside the largest frame
    `NRFS_ASSERT_IMP(a_slot_range, done && !result.status, result.slot_number < 8'd160)

endmodule

bind nr_frame_slot_timing_locator nrfs_checker u_nrfs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

@@ bench/testbench.sv @@
// self-checking bench for nr_frame_slot_timing_locator: directed and random beats
// depends on nrfs_pkg and the locator rtl; the scoreboard class predicts every result
`timescale 1ns / 100ps

module testbench;
    import nrfs_pkg::*;

    localparam longint unsigned MASK63     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int unsigned     CYCLE_CAP  = 2_000_000;
    localparam int unsigned     TAIL_WAIT  = 300;
    localparam int unsigned     SHOW_LIMIT = 10;

    // timing predictor and store of expected results
    class timing_scoreboard;
        bit [63:0]    fft_n;
        bit [63:0]    mu_reg;
        bit [63:0]    sfn_at_ref;
        bit [63:0]    sync_slot;
        bit [63:0]    sync_sym;
        bit [63:0]    ready;
        bit [63:0]    frame_start;
        bit           have_ref;
        nrfs_result_t awaited[$];
        int unsigned  errors;

        function new();
            fft_n       = 64'd2048;
            mu_reg      = 0;
            sfn_at_ref  = 0;
            sync_slot   = 0;
            sync_sym    = 0;
            ready       = 0;
            frame_start = 0;
            have_ref    = 0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, bit [63:0] val);
            case (idx)
                REG_FFT_SIZE:    fft_n      = val & 64'h1FFF;
                REG_NUMEROLOGY:  mu_reg     = val & 64'h7;
                REG_SFN_AT_REF:  sfn_at_ref = val & 64'h3FF;
                REG_SYNC_SLOT:   sync_slot  = val & 64'hFF;
                REG_SYNC_SYMBOL: sync_sym   = val & 64'hF;
                REG_CELL_READY:  ready      = val & 64'h1;
                default: ;
            endcase
        endfunction

        // symbol length: fft plus short or long prefix
        function bit [63:0] sym_samples(bit [63:0] idx);
            bit [63:0] cp;
            if (idx % (64'd7 << mu_reg) == 0)
                cp = ((64'd144 + (64'd16 << mu_reg)) * fft_n + 64'd1024) >> 11;
            else
                cp = (64'd144 * fft_n + 64'd1024) >> 11;
            return fft_n + cp;
        endfunction

        function bit [63:0] slot_samples(bit [63:0] slot);
            bit [63:0] total;
            total = 0;
            for (int s = 0; s < 14; s++)
                total += sym_samples(slot * 14 + s);
            return total;
        endfunction

        function bit [63:0] span_of_slots(bit [63:0] count);
            bit [63:0] total;
            total = 0;
            for (bit [63:0] s = 0; s < count; s++)
                total += slot_samples(s);
            return total;
        endfunction

        // reference update, returns reject flag
        function bit set_timing(nrfs_item_t it, bit [63:0] spf);
            bit [63:0] sym_off;
            bit [63:0] slot_start;
            bit [63:0] before_slot;
            longint    rel;
            sym_off = 0;
            if (sync_slot >= spf)
                return 1;
            for (bit [63:0] s = 0; s < sync_sym % 14; s++)
                sym_off += sym_samples(sync_slot * 14 + s);
            rel = longint'({32'b0, it.coarse_offset}) + longint'(it.tracking_shift);
            if (rel < 0 || 64'(rel) < sym_off)
                return 1;
            slot_start = {1'b0, it.block_first_sample} + (64'(rel) - sym_off);
            if (slot_start > MASK63)
                return 1;
            before_slot = span_of_slots(sync_slot);
            if (slot_start < before_slot)
                return 1;
            frame_start = slot_start - before_slot;
            have_ref    = 1;
            return 0;
        endfunction

        function nrfs_result_t predict(nrfs_item_t it);
            nrfs_result_t r;
            bit [63:0] spf, flen, q, d, k, rem, adv, frame_pos, pos, len, slot, back;
            bit        found;
            r = '0;
            r.status = 1'b1;
            if (ready == 0 || mu_reg > MAX_NUMEROLOGY)
                return r;
            spf = 64'd10 << mu_reg;
            if (it.op == 1'b0) begin
                r.status = set_timing(it, spf);
                return r;
            end
            if (!have_ref)
                return r;
            flen = span_of_slots(spf);
            if (flen == 0)
                return r;
            q = {1'b0, it.query_sample};
            // floor division of the distance to the frame start
            if (q >= frame_start) begin
                d         = q - frame_start;
                adv       = d / flen;
                frame_pos = d % flen;
            end
            else begin
                d   = frame_start - q;
                k   = d / flen;
                rem = d % flen;
                if (rem == 0) begin
                    adv       = -k;
                    frame_pos = 0;
                end
                else begin
                    adv       = -(k + 1);
                    frame_pos = flen - rem;
                end
            end
            // walk the slots of the frame
            pos   = 0;
            slot  = 0;
            found = 0;
            for (bit [63:0] s = 0; s < spf && !found; s++) begin
                len = slot_samples(s);
                if (frame_pos < pos + len) begin
                    slot  = s;
                    found = 1;
                end
                else
                    pos += len;
            end
            back                = frame_pos - pos;
            r.status            = 1'b0;
            r.frame_number      = SFN_W'(sfn_at_ref + adv);
            r.slot_number       = SLOT_W'(slot);
            r.slot_first_sample = (back > q) ? '0 : SAMPLE_W'(q - back);
            return r;
        endfunction

        function void note_item(nrfs_item_t it);
            awaited.push_back(predict(it));
        endfunction

        function void fail_note(string what, nrfs_result_t exp_r, nrfs_result_t got);
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%s: expected st=%0d sfn=%0d slot=%0d first=%0d,",
                         what, exp_r.status, exp_r.frame_number, exp_r.slot_number,
                         exp_r.slot_first_sample,
                         " got st=%0d sfn=%0d slot=%0d first=%0d",
                         got.status, got.frame_number,
                         got.slot_number, got.slot_first_sample);
        endfunction

        function void check_result(nrfs_result_t got);
            nrfs_result_t exp_r;
            if (awaited.size() == 0) begin
                fail_note("unexpected result", '0, got);
                return;
            end
            exp_r = awaited.pop_front();
            if (got.status !== exp_r.status)
                fail_note("status mismatch", exp_r, got);
            else if (got.frame_number !== exp_r.frame_number)
                fail_note("frame number mismatch", exp_r, got);
            else if (got.slot_number !== exp_r.slot_number)
                fail_note("slot mismatch", exp_r, got);
            else if (got.slot_first_sample !== exp_r.slot_first_sample)
                fail_note("slot start mismatch", exp_r, got);
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    nrfs_item_t            item;
    logic                  done;
    nrfs_result_t          result;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    timing_scoreboard sb;
    int unsigned      cycles;
    int unsigned      idle_pct;

    nr_frame_slot_timing_locator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("nr_frame_slot_timing_locator verification failed");
            $finish;
        end
    end

    // monitor: result beat checked before the new command beat is noted
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_item(item);
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, 64'(val));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(logic [CFG_DATA_W-1:0] fft, logic [CFG_DATA_W-1:0] mu,
                             logic [CFG_DATA_W-1:0] sfn, logic [CFG_DATA_W-1:0] slot,
                             logic [CFG_DATA_W-1:0] sym, logic [CFG_DATA_W-1:0] rdy);
        write_reg(REG_FFT_SIZE, fft);
        write_reg(REG_NUMEROLOGY, mu);
        write_reg(REG_SFN_AT_REF, sfn);
        write_reg(REG_SYNC_SLOT, slot);
        write_reg(REG_SYNC_SYMBOL, sym);
        write_reg(REG_CELL_READY, rdy);
    endtask

    // one command beat; start is left high at the accepting edge
    task automatic send_beat(nrfs_item_t it);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    // hold off until every result is in, then let the block settle
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (12) @(posedge clk);
    endtask

    function automatic nrfs_item_t mk(bit o, bit [62:0] blk, bit [31:0] co,
                                      bit [31:0] sh, bit [62:0] q);
        nrfs_item_t it;
        it.op                 = o;
        it.block_first_sample = blk;
        it.coarse_offset      = co;
        it.tracking_shift     = sh;
        it.query_sample       = q;
        return it;
    endfunction

    function automatic bit [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    // random beat: mostly plausible references and queries near the frame start
    function automatic nrfs_item_t rand_beat();
        nrfs_item_t it;
        longint     off;
        it = mk(1'b1, rand63(), $urandom, $urandom, rand63());
        if ($urandom_range(99) < 20) begin
            it.op = 1'b0;
            if ($urandom_range(9) != 0)
                it.block_first_sample = 63'({$urandom_range(255), $urandom});
            if ($urandom_range(1) == 0)
                it.tracking_shift = 32'($signed($urandom_range(20000)) - 10000);
        end
        else if ($urandom_range(99) < 85) begin
            off = longint'($urandom_range(60_000_000)) - 30_000_000;
            it.query_sample = 63'(sb.frame_start + 64'(off));
        end
        return it;
    endfunction

    task automatic run_phase(int unsigned count, int unsigned idle);
        idle_pct = idle;
        repeat (count) send_beat(rand_beat());
        drain();
    endtask

    initial
    begin
        sb        = new();
        cycles    = 0;
        idle_pct  = 0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cell not ready after reset
        send_beat(mk(1'b0, 63'd1000, 32'd5000, 32'd0, 63'd0));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, 63'd12345));
        drain();

        // directed: mu 1, sync block at slot 5 symbol 3
        write_all(13'd2048, 13'd1, 13'd1023, 13'd5, 13'd3, 13'd1);
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, 63'd0));
        send_beat(mk(1'b0, 63'd0, 32'd0, 32'd0, 63'd0));
        send_beat(mk(1'b0, 63'd0, 32'd100, -32'sd200, 63'd0));
        send_beat(mk(1'b0, 63'd0, 32'd10000, 32'd0, 63'd0));
        send_beat(mk(1'b0, MASK63[62:0], 32'hFFFF_FFFF, 32'h7FFF_FFFF, 63'd0));
        send_beat(mk(1'b0, 63'd1_000_000_000, 32'd50000, -32'sd3000, 63'd0));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, 63'd0));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, MASK63[62:0]));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, 63'(sb.frame_start)));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, 63'd999_999_999));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, 63'd1_000_400_000));
        send_beat(mk(1'b0, 63'd0, 32'hFFFF_FFFF, 32'h8000_0000, 63'd0));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, 63'd1));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, 63'd5_000_000));
        send_beat(mk(1'b0, MASK63[62:0] - 63'd10, 32'd0, 32'd0, 63'd0));
        send_beat(mk(1'b1, 63'd0, 32'd0, 32'd0, MASK63[62:0]));
        drain();

        // random phases across settings, extremes among them
        write_all(13'd128, 13'd0, 13'd0, 13'd0, 13'd0, 13'd1);
        run_phase(55, 0);
        write_all(13'd4096, 13'd4, 13'd1023, 13'd159, 13'd13, 13'd1);
        run_phase(55, 83);
        write_all(13'd2048, 13'd2, 13'($urandom_range(1023)), 13'($urandom_range(39)),
                  13'd15, 13'd1);
        run_phase(55, 0);
        write_all(13'd8191, 13'd3, 13'($urandom_range(1023)), 13'd79, 13'd14, 13'h1FFF);
        run_phase(45, 34);
        write_all(13'd0, 13'd3, 13'd0, 13'd0, 13'd0, 13'd1);
        run_phase(20, 83);
        write_all(13'd1024, 13'h1FFD, 13'd7, 13'd3, 13'd2, 13'd1);
        run_phase(20, 34);
        write_all(13'd512, 13'd1, 13'd100, 13'd20, 13'd0, 13'd1);
        run_phase(20, 0);
        write_all(13'd2048, 13'h1FFF, 13'h1FFF, 13'hFF, 13'hF, 13'h1FFE);
        run_phase(15, 34);
        for (int p = 0; p < 3; p++) begin
            write_all(13'($urandom_range(4096, 128)), 13'(p + 1),
                      13'($urandom_range(1023)), 13'($urandom_range((10 << (p + 1)) - 1)),
                      13'($urandom_range(13)), 13'd1);
            run_phase(40, (p == 1) ? 83 : 34);
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("nr_frame_slot_timing_locator verification clean");
        else
            $display("nr_frame_slot_timing_locator verification failed");
        $finish;
    end

endmodule
